>>> rtl/one_wire_bus_master_unit_macros.svh
// assertion macros for the one wire bus master checker
`ifndef ONE_WIRE_BUS_MASTER_UNIT_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define OWBM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("one wire master check failed");

// next-cycle implication, held off during reset
`define OWBM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("one wire master check failed");

`endif

>>> rtl/owbm_pkg.sv
// shared types and constants for the one wire bus master
package owbm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_W         = $clog2(BITS_PER_BYTE);
    localparam int LONG_W        = 10;
    localparam int SHORT_W       = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 10;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LOW   = 3'd1,
        PH_WAIT  = 3'd2,
        PH_REL   = 3'd3,
        PH_RECOV = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_RECOV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PULSE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PULSE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE  = 3'd5;

    localparam logic [LONG_W-1:0]  RST_RESET_LOW     = 10'd600;
    localparam logic [LONG_W-1:0]  RST_PRESENCE_WAIT = 10'd100;
    localparam logic [LONG_W-1:0]  RST_RESET_RECOV   = 10'd600;
    localparam logic [SHORT_W-1:0] RST_SHORT_PULSE   = 8'd2;
    localparam logic [SHORT_W-1:0] RST_LONG_PULSE    = 8'd80;
    localparam logic [SHORT_W-1:0] RST_READ_SAMPLE   = 8'd6;

    typedef struct packed {
        logic [LONG_W-1:0]  reset_low;
        logic [LONG_W-1:0]  presence_wait;
        logic [LONG_W-1:0]  reset_recov;
        logic [SHORT_W-1:0] short_pulse;
        logic [SHORT_W-1:0] long_pulse;
        logic [SHORT_W-1:0] read_sample;
    } t_cfg;

    typedef struct packed {
        logic                     drive_low;
        logic                     busy_res;
        logic                     done_res;
        logic [BITS_PER_BYTE-1:0] read_data;
        logic                     presence;
        logic                     rejected;
    } t_result;

endpackage

>>> rtl/owbm_cfg.sv
// timing configuration registers
module owbm_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output owbm_pkg::t_cfg                      o_cfg
);

    owbm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low     <= owbm_pkg::RST_RESET_LOW;
            r_cfg.presence_wait <= owbm_pkg::RST_PRESENCE_WAIT;
            r_cfg.reset_recov   <= owbm_pkg::RST_RESET_RECOV;
            r_cfg.short_pulse   <= owbm_pkg::RST_SHORT_PULSE;
            r_cfg.long_pulse    <= owbm_pkg::RST_LONG_PULSE;
            r_cfg.read_sample   <= owbm_pkg::RST_READ_SAMPLE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                owbm_pkg::CFG_RESET_LOW:
                    r_cfg.reset_low <= i_cfg_data[owbm_pkg::LONG_W-1:0];
                owbm_pkg::CFG_PRESENCE_WAIT:
                    r_cfg.presence_wait <= i_cfg_data[owbm_pkg::LONG_W-1:0];
                owbm_pkg::CFG_RESET_RECOV:
                    r_cfg.reset_recov <= i_cfg_data[owbm_pkg::LONG_W-1:0];
                owbm_pkg::CFG_SHORT_PULSE:
                    r_cfg.short_pulse <= i_cfg_data[owbm_pkg::SHORT_W-1:0];
                owbm_pkg::CFG_LONG_PULSE:
                    r_cfg.long_pulse <= i_cfg_data[owbm_pkg::SHORT_W-1:0];
                owbm_pkg::CFG_READ_SAMPLE:
                    r_cfg.read_sample <= i_cfg_data[owbm_pkg::SHORT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/owbm_core.sv
// bus timing state machine: one item per step
module owbm_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic [1:0]                          i_req_type,
    input  logic [owbm_pkg::BITS_PER_BYTE-1:0]  i_write_byte,
    input  logic                                i_line_level,
    input  owbm_pkg::t_cfg                      i_cfg,
    output owbm_pkg::t_result                   o_result
);

    owbm_pkg::t_phase                   r_phase, n_phase;
    owbm_pkg::t_op                      r_op, n_op;
    logic [owbm_pkg::LONG_W-1:0]        r_tick, n_tick;
    logic [owbm_pkg::BIT_W-1:0]         r_bit, n_bit;
    logic [owbm_pkg::BITS_PER_BYTE-1:0] r_shift, n_shift;
    logic                               r_pres, n_pres;
    logic [owbm_pkg::BITS_PER_BYTE-1:0] r_held, n_held;

    owbm_pkg::t_op                      req;
    logic [owbm_pkg::LONG_W-1:0]        len;
    logic [owbm_pkg::LONG_W-1:0]        cnt;
    logic                               cur_bit;
    logic                               last_bit;
    logic                               fin;
    logic                               done_hit;
    logic                               reject_hit;

    assign req      = owbm_pkg::t_op'(i_req_type);
    assign cur_bit  = r_shift[r_bit];
    assign last_bit = (r_bit == owbm_pkg::BIT_W'(owbm_pkg::BITS_PER_BYTE - 1));
    assign cnt      = r_tick + owbm_pkg::LONG_W'(1);

    // length of the current phase
    always_comb begin
        len = '0;
        case (r_op)
            owbm_pkg::OP_RESET: begin
                if (r_phase == owbm_pkg::PH_LOW) begin
                    len = i_cfg.reset_low;
                end else if (r_phase == owbm_pkg::PH_WAIT) begin
                    len = i_cfg.presence_wait;
                end else begin
                    len = i_cfg.reset_recov;
                end
            end
            owbm_pkg::OP_WRITE: begin
                if ((r_phase == owbm_pkg::PH_LOW) == cur_bit) begin
                    len = owbm_pkg::LONG_W'(i_cfg.short_pulse);
                end else begin
                    len = owbm_pkg::LONG_W'(i_cfg.long_pulse);
                end
            end
            owbm_pkg::OP_READ: begin
                if (r_phase == owbm_pkg::PH_LOW) begin
                    len = owbm_pkg::LONG_W'(i_cfg.short_pulse);
                end else if (r_phase == owbm_pkg::PH_WAIT) begin
                    len = owbm_pkg::LONG_W'(i_cfg.read_sample);
                end else begin
                    len = owbm_pkg::LONG_W'(i_cfg.long_pulse);
                end
            end
            default: begin
                len = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_op       = r_op;
        n_tick     = r_tick;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_pres     = r_pres;
        n_held     = r_held;
        fin        = 1'b0;
        reject_hit = 1'b0;
        if (req != owbm_pkg::OP_TICK) begin
            if (r_phase != owbm_pkg::PH_IDLE) begin
                reject_hit = 1'b1;
            end else begin
                n_op    = req;
                n_phase = owbm_pkg::PH_LOW;
                n_tick  = '0;
                n_bit   = '0;
                case (req)
                    owbm_pkg::OP_WRITE: n_shift = i_write_byte;
                    owbm_pkg::OP_READ:  n_shift = '0;
                    default:            n_pres  = 1'b0;
                endcase
            end
        end else if (r_phase != owbm_pkg::PH_IDLE) begin
            if (cnt >= len) begin
                n_tick = '0;
                case (r_op)
                    owbm_pkg::OP_RESET: begin
                        if (r_phase == owbm_pkg::PH_LOW) begin
                            n_phase = owbm_pkg::PH_WAIT;
                        end else if (r_phase == owbm_pkg::PH_WAIT) begin
                            n_pres = !i_line_level;
                            if (i_cfg.reset_recov == '0) begin
                                fin = 1'b1;
                            end else begin
                                n_phase = owbm_pkg::PH_RECOV;
                            end
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    owbm_pkg::OP_WRITE: begin
                        if (r_phase == owbm_pkg::PH_LOW) begin
                            n_phase = owbm_pkg::PH_REL;
                        end else if (last_bit) begin
                            fin = 1'b1;
                        end else begin
                            n_bit   = r_bit + owbm_pkg::BIT_W'(1);
                            n_phase = owbm_pkg::PH_LOW;
                        end
                    end
                    default: begin
                        if (r_phase == owbm_pkg::PH_LOW) begin
                            n_phase = owbm_pkg::PH_WAIT;
                        end else if (r_phase == owbm_pkg::PH_WAIT) begin
                            if (i_line_level) begin
                                n_shift[r_bit] = 1'b1;
                            end
                            n_phase = owbm_pkg::PH_REL;
                        end else if (last_bit) begin
                            fin    = 1'b1;
                            n_held = r_shift;
                        end else begin
                            n_bit   = r_bit + owbm_pkg::BIT_W'(1);
                            n_phase = owbm_pkg::PH_LOW;
                        end
                    end
                endcase
            end else begin
                n_tick = cnt;
            end
        end
        if (fin) begin
            n_phase = owbm_pkg::PH_IDLE;
            n_op    = owbm_pkg::OP_TICK;
            n_bit   = '0;
        end
        done_hit = fin;
    end

    // result of this item
    always_comb begin
        o_result.drive_low = (n_phase == owbm_pkg::PH_LOW);
        o_result.busy_res  = (n_phase != owbm_pkg::PH_IDLE);
        o_result.done_res  = done_hit;
        o_result.read_data = n_held;
        o_result.presence  = n_pres;
        o_result.rejected  = reject_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= owbm_pkg::PH_IDLE;
            r_op    <= owbm_pkg::OP_TICK;
            r_tick  <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_pres  <= 1'b0;
            r_held  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_op    <= n_op;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_pres  <= n_pres;
            r_held  <= n_held;
        end
    end

endmodule

>>> rtl/one_wire_bus_master_unit.sv
// top level of the one wire bus master: input register, state machine, result register
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_ready    i_req_type, i_write_byte, i_line_level
//   out       output     o_out_valid / i_out_ready  o_drive_low .. o_rejected
//   cfg       input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// one item per cycle unless the output stalls; a taken item passes the input register first
// the state machine steps when the input register holds an item and the result register frees
// a stalled output holds the result and the input register, o_in_ready drops once both are full
// synchronous active-low reset clears the state machine, both valid flags and the timing values
module one_wire_bus_master_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_req_type,
    input  logic [owbm_pkg::BITS_PER_BYTE-1:0]  i_write_byte,
    input  logic                                i_line_level,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_drive_low,
    output logic                                o_busy_res,
    output logic                                o_done_res,
    output logic [owbm_pkg::BITS_PER_BYTE-1:0]  o_read_data,
    output logic                                o_presence,
    output logic                                o_rejected,
    input  logic                                i_cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic                               r_in_valid;
    logic [1:0]                         r_req;
    logic [owbm_pkg::BITS_PER_BYTE-1:0] r_wbyte;
    logic                               r_line;
    logic                               r_out_valid;
    owbm_pkg::t_result                  r_out;

    owbm_pkg::t_cfg                     cfg;
    owbm_pkg::t_result                  result;
    logic                               step;

    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    owbm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    owbm_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_req_type   (r_req),
        .i_write_byte (r_wbyte),
        .i_line_level (r_line),
        .i_cfg        (cfg),
        .o_result     (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req   <= i_req_type;
            r_wbyte <= i_write_byte;
            r_line  <= i_line_level;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive_low = r_out.drive_low;
    assign o_busy_res  = r_out.busy_res;
    assign o_done_res  = r_out.done_res;
    assign o_read_data = r_out.read_data;
    assign o_presence  = r_out.presence;
    assign o_rejected  = r_out.rejected;

endmodule

>>> rtl/owbm_checker.sv
// port checks for the one wire bus master, bound to the top level
`include "one_wire_bus_master_unit_macros.svh"

module owbm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic                                o_drive_low,
    input logic                                o_busy_res,
    input logic                                o_done_res,
    input logic                                o_rejected
);

    // a result waits until it is taken
    `OWBM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)

    // a finished operation leaves the master idle
    `OWBM_ASSERT_NOW(a_done_idle, o_out_valid && o_done_res, !o_busy_res && !o_rejected)

    // the line is pulled low only during an operation
    `OWBM_ASSERT_NOW(a_low_busy, o_out_valid && o_drive_low, o_busy_res)

    // a refused start leaves the running operation in place
    `OWBM_ASSERT_NOW(a_reject_busy, o_out_valid && o_rejected, o_busy_res)

endmodule

bind one_wire_bus_master_unit owbm_checker u_owbm_checker (.*);

>>> dv/tb.sv
// self-checking testbench for the one wire bus master unit, driven and checked per transfer
module tb;
    import owbm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct {
        t_op                      req;
        logic [BITS_PER_BYTE-1:0] wb;
        logic                     line;
    } t_wire_item;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               req_type = OP_TICK;
    logic [BITS_PER_BYTE-1:0] write_byte = '0;
    logic                     line_level = 1'b1;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     drive_low;
    logic                     busy_res;
    logic                     done_res;
    logic [BITS_PER_BYTE-1:0] read_data;
    logic                     presence;
    logic                     rejected;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_idx = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    t_wire_item bus_requests[$];
    t_result    bus_expected[$];
    int         n_queued = 0;
    int         n_checked = 0;
    int         n_bad = 0;
    int         idle_pct = 6;

    // predicted state of the master
    t_phase                   bus_phase;
    t_op                      bus_op;
    logic [LONG_W-1:0]        slot_ticks;
    logic [BIT_W-1:0]         bit_pos;
    logic [BITS_PER_BYTE-1:0] shreg;
    logic                     pres_seen;
    logic [BITS_PER_BYTE-1:0] last_read;
    t_cfg                     timing;

    one_wire_bus_master_unit dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_req_type   (req_type),
        .i_write_byte (write_byte),
        .i_line_level (line_level),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_drive_low  (drive_low),
        .o_busy_res   (busy_res),
        .o_done_res   (done_res),
        .o_read_data  (read_data),
        .o_presence   (presence),
        .o_rejected   (rejected),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void bus_reset();
        bus_phase  = PH_IDLE;
        bus_op     = OP_TICK;
        slot_ticks = '0;
        bit_pos    = '0;
        shreg      = '0;
        pres_seen  = 1'b0;
        last_read  = '0;
        timing     = {RST_RESET_LOW, RST_PRESENCE_WAIT, RST_RESET_RECOV,
                      RST_SHORT_PULSE, RST_LONG_PULSE, RST_READ_SAMPLE};
    endfunction

    function automatic logic [LONG_W-1:0] slot_length();
        logic cur;
        cur = shreg[bit_pos];
        case (bus_op)
            OP_RESET: begin
                if (bus_phase == PH_LOW) return timing.reset_low;
                if (bus_phase == PH_WAIT) return timing.presence_wait;
                return timing.reset_recov;
            end
            OP_WRITE: begin
                if (bus_phase == PH_LOW)
                    return cur ? LONG_W'(timing.short_pulse) : LONG_W'(timing.long_pulse);
                return cur ? LONG_W'(timing.long_pulse) : LONG_W'(timing.short_pulse);
            end
            default: begin
                if (bus_phase == PH_LOW) return LONG_W'(timing.short_pulse);
                if (bus_phase == PH_WAIT) return LONG_W'(timing.read_sample);
                return LONG_W'(timing.long_pulse);
            end
        endcase
    endfunction

    // closes a bit slot, returns 1 once the whole byte is through
    function automatic logic close_slot();
        if (bit_pos == BIT_W'(BITS_PER_BYTE - 1)) return 1'b1;
        bit_pos   = bit_pos + BIT_W'(1);
        bus_phase = PH_LOW;
        return 1'b0;
    endfunction

    function automatic t_result bus_step(input t_op req, input logic [BITS_PER_BYTE-1:0] wb,
                                         input logic line);
        t_result           r;
        logic [LONG_W-1:0] cnt;
        logic              fin;
        r   = '0;
        fin = 1'b0;
        if (req != OP_TICK) begin
            if (bus_phase != PH_IDLE) begin
                r.rejected = 1'b1;
            end else begin
                bus_op     = req;
                bus_phase  = PH_LOW;
                slot_ticks = '0;
                bit_pos    = '0;
                if (req == OP_WRITE) shreg = wb;
                else if (req == OP_READ) shreg = '0;
                else pres_seen = 1'b0;
            end
        end else if (bus_phase != PH_IDLE) begin
            cnt = slot_ticks + LONG_W'(1);
            if (cnt >= slot_length()) begin
                slot_ticks = '0;
                case (bus_op)
                    OP_RESET: begin
                        if (bus_phase == PH_LOW) begin
                            bus_phase = PH_WAIT;
                        end else if (bus_phase == PH_WAIT) begin
                            pres_seen = ~line;
                            if (timing.reset_recov == '0) fin = 1'b1;
                            else bus_phase = PH_RECOV;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    OP_WRITE: begin
                        if (bus_phase == PH_LOW) bus_phase = PH_REL;
                        else fin = close_slot();
                    end
                    default: begin
                        if (bus_phase == PH_LOW) begin
                            bus_phase = PH_WAIT;
                        end else if (bus_phase == PH_WAIT) begin
                            if (line) shreg[bit_pos] = 1'b1;
                            bus_phase = PH_REL;
                        end else begin
                            fin = close_slot();
                            if (fin) last_read = shreg;
                        end
                    end
                endcase
                if (fin) begin
                    bus_phase  = PH_IDLE;
                    bus_op     = OP_TICK;
                    bit_pos    = '0;
                    r.done_res = 1'b1;
                end
            end else begin
                slot_ticks = cnt;
            end
        end
        r.drive_low = (bus_phase == PH_LOW);
        r.busy_res  = (bus_phase != PH_IDLE);
        r.read_data = last_read;
        r.presence  = pres_seen;
        return r;
    endfunction

    function automatic void cmp_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
        if (got !== want) begin
            $error("%s expected %0h actual %0h", name, want, got);
            n_bad++;
        end
    endfunction

    // driver
    always @(posedge clk) begin : drv
        t_wire_item it;
        if (!rst_n) begin
            in_valid <= 1'b0;
            bus_reset();
        end else begin
            if (in_valid && in_ready)
                bus_expected.push_back(bus_step(t_op'(req_type), write_byte, line_level));
            if (!in_valid || in_ready) begin
                if (bus_requests.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
                    it = bus_requests.pop_front();
                    in_valid   <= 1'b1;
                    req_type   <= it.req;
                    write_byte <= it.wb;
                    line_level <= it.line;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin : mon
        t_result w;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (bus_expected.size() == 0) begin
                    $error("result transfer with nothing expected");
                    n_bad++;
                end else begin
                    w = bus_expected.pop_front();
                    cmp_field("drive_low", 8'(w.drive_low), 8'(drive_low));
                    cmp_field("busy_res", 8'(w.busy_res), 8'(busy_res));
                    cmp_field("done_res", 8'(w.done_res), 8'(done_res));
                    cmp_field("read_data", w.read_data, read_data);
                    cmp_field("presence", 8'(w.presence), 8'(presence));
                    cmp_field("rejected", 8'(w.rejected), 8'(rejected));
                    n_checked++;
                end
            end
            out_ready <= ($urandom_range(99, 0) >= idle_pct);
        end
    end

    function automatic void push_item(input t_op req, input logic [BITS_PER_BYTE-1:0] wb,
                                      input logic line);
        t_wire_item it;
        it.req  = req;
        it.wb   = wb;
        it.line = line;
        bus_requests.push_back(it);
        n_queued++;
    endfunction

    function automatic int at_least_one(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic int op_ticks(input t_op kind);
        int s;
        int l;
        s = at_least_one(int'(timing.short_pulse));
        l = at_least_one(int'(timing.long_pulse));
        case (kind)
            OP_RESET: return at_least_one(int'(timing.reset_low)) +
                             at_least_one(int'(timing.presence_wait)) +
                             int'(timing.reset_recov);
            OP_WRITE: return BITS_PER_BYTE * (s + l);
            default:  return BITS_PER_BYTE * (s + at_least_one(int'(timing.read_sample)) + l);
        endcase
    endfunction

    // start request, then ticks; stray requests only while the operation should be running
    task automatic add_op(input t_op kind, input int ticks, input int need);
        int i;
        push_item(kind, 8'($urandom), 1'($urandom));
        for (i = 0; i < ticks; i++) begin
            if (i < need && $urandom_range(99, 0) < 4)
                push_item(t_op'($urandom_range(3, 1)), 8'($urandom), 1'($urandom));
            push_item(OP_TICK, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic run_random(input int budget);
        int   used;
        int   need;
        int   ticks;
        int   i;
        t_op  kind;
        used = 0;
        while (used < budget) begin
            kind = t_op'($urandom_range(3, 1));
            need = op_ticks(kind);
            if ($urandom_range(99, 0) < 15) ticks = $urandom_range(need - 1, 0);
            else ticks = need + $urandom_range(3, 0);
            add_op(kind, ticks, need);
            used += ticks + 1;
        end
        // let any leftover operation run out
        need = op_ticks(OP_READ) + op_ticks(OP_RESET) + 2;
        for (i = 0; i < need; i++) push_item(OP_TICK, 8'($urandom), 1'($urandom));
    endtask

    task automatic settle();
        while (n_checked < n_queued) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_RESET_LOW:     timing.reset_low     = val;
            CFG_PRESENCE_WAIT: timing.presence_wait = val;
            CFG_RESET_RECOV:   timing.reset_recov   = val;
            CFG_SHORT_PULSE:   timing.short_pulse   = val[SHORT_W-1:0];
            CFG_LONG_PULSE:    timing.long_pulse    = val[SHORT_W-1:0];
            CFG_READ_SAMPLE:   timing.read_sample   = val[SHORT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_cfg(input int rl, input int pw, input int rc,
                            input int sp, input int lp, input int rs);
        put_reg(CFG_RESET_LOW, CFG_DATA_W'(rl));
        put_reg(CFG_PRESENCE_WAIT, CFG_DATA_W'(pw));
        put_reg(CFG_RESET_RECOV, CFG_DATA_W'(rc));
        put_reg(CFG_SHORT_PULSE, CFG_DATA_W'(sp));
        put_reg(CFG_LONG_PULSE, CFG_DATA_W'(lp));
        put_reg(CFG_READ_SAMPLE, CFG_DATA_W'(rs));
    endtask

    // short timings, with junk in the upper data bits of the narrow registers
    task automatic load_small_cfg();
        load_cfg($urandom_range(8, 1), $urandom_range(8, 1), $urandom_range(8, 0),
                 $urandom_range(4, 1) | ($urandom_range(3, 0) << 8),
                 $urandom_range(6, 1) | ($urandom_range(3, 0) << 8),
                 $urandom_range(4, 1) | ($urandom_range(3, 0) << 8));
    endtask

    initial begin : stim
        int i;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset timing values: first read slot and the start of the second
        add_op(OP_READ, 90, 0);
        settle();

        load_cfg(1, 1, 0, 1, 1, 1);
        // finish the read with short timings
        for (i = 0; i < 24; i++) push_item(OP_TICK, 8'($urandom), 1'($urandom));
        push_item(OP_TICK, 8'h00, 1'b0);
        push_item(OP_TICK, 8'hFF, 1'b1);
        push_item(OP_RESET, 8'h00, 1'b0);
        push_item(OP_RESET, 8'hFF, 1'b1);
        push_item(OP_WRITE, 8'hFF, 1'b1);
        push_item(OP_READ, 8'h00, 1'b0);
        push_item(OP_TICK, 8'h00, 1'b1);
        // device answers, recovery skipped
        push_item(OP_TICK, 8'h00, 1'b0);
        push_item(OP_WRITE, 8'hFF, 1'b0);
        for (i = 0; i < 16; i++) push_item(OP_TICK, 8'h00, 1'b1);
        settle();

        idle_pct = 0;
        load_small_cfg();
        run_random(70);
        settle();

        idle_pct = 6;
        load_small_cfg();
        put_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
        put_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
        run_random(70);
        settle();

        // zero durations
        load_cfg(0, 0, 0, 0, 0, 0);
        run_random(60);
        settle();

        load_small_cfg();
        run_random(70);
        settle();

        load_cfg(1, 1, 1, 1, 1, 1);
        run_random(60);
        settle();

        // longest timings, start of a write only
        load_cfg(1023, 1023, 1023, 255, 255, 255);
        add_op(OP_WRITE, 40, 40);
        settle();

        repeat (10) @(posedge clk);
        if (n_bad == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        #8000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
